/* rtl/fsg_pkg.sv */
`default_nettype none
package fsg_pkg;

	localparam int RECORDS_DEF  = 64;
	localparam int SESSIONS_DEF = 8;
	localparam int USED_W       = 6;
	localparam int PADDR_W      = 5;

	localparam int UDP_WINDOW_MS = 1000;
	localparam int TCP_WINDOW_MS = 60000;

	localparam logic [1:0] OP_UDP  = 2'd0;
	localparam logic [1:0] OP_TCP  = 2'd1;
	localparam logic [1:0] OP_UP   = 2'd2;
	localparam logic [1:0] OP_DOWN = 2'd3;

	localparam logic [1:0] CLS_PING = 2'd1;
	localparam logic [1:0] CLS_REG  = 2'd2;

	localparam logic [3:0] V_OK       = 4'd0;
	localparam logic [3:0] V_TRUSTED  = 4'd1;
	localparam logic [3:0] V_BANNED   = 4'd2;
	localparam logic [3:0] V_OVERSIZE = 4'd3;
	localparam logic [3:0] V_UNKNOWN  = 4'd4;
	localparam logic [3:0] V_FLOOD    = 4'd5;
	localparam logic [3:0] V_FULL     = 4'd6;
	localparam logic [3:0] V_SESSION  = 4'd7;
	localparam logic [3:0] V_SET_FULL = 4'd8;

	localparam logic [2:0] REG_UDP_BASE  = 3'd0;
	localparam logic [2:0] REG_UDP_EXTRA = 3'd1;
	localparam logic [2:0] REG_TCP_BASE  = 3'd2;
	localparam logic [2:0] REG_TCP_EXTRA = 3'd3;
	localparam logic [2:0] REG_BAN_BASE  = 3'd4;
	localparam logic [2:0] REG_TIMEOUT   = 3'd5;
	localparam logic [2:0] REG_TRUSTED   = 3'd6;
	localparam logic [2:0] REG_MAX_SIZE  = 3'd7;

	localparam logic [15:0] RST_UDP_BASE  = 16'd150;
	localparam logic [15:0] RST_UDP_EXTRA = 16'd50;
	localparam logic [15:0] RST_TCP_BASE  = 16'd10;
	localparam logic [15:0] RST_TCP_EXTRA = 16'd5;
	localparam logic [31:0] RST_BAN_BASE  = 32'd60000;
	localparam logic [31:0] RST_TIMEOUT   = 32'd600000;
	localparam logic [31:0] RST_TRUSTED   = 32'h7F00_0001;
	localparam logic [15:0] RST_MAX_SIZE  = 16'd1450;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] source_ip;
		logic [31:0] session_id;
		logic [15:0] datagram_size;
		logic [1:0]  packet_class;
		logic [47:0] now_ms;
	} in_t;

	typedef struct packed {
		logic       allow;
		logic [3:0] verdict;
		logic       ban_issued;
		logic [3:0] live_sessions;
		logic [7:0] violation_total;
	} out_t;

	typedef struct packed {
		logic [15:0] udp_base;
		logic [15:0] udp_extra;
		logic [15:0] tcp_base;
		logic [15:0] tcp_extra;
		logic [31:0] ban_base;
		logic [31:0] timeout;
		logic [31:0] trusted;
		logic [15:0] max_size;
	} cfg_t;

	typedef struct packed {
		logic [31:0]       address;
		logic              ban;
		logic [47:0]       expiry;
		logic [7:0]        viol;
		logic [15:0]       udp_cnt;
		logic [47:0]       udp_ws;
		logic [15:0]       tcp_cnt;
		logic [47:0]       tcp_ws;
		logic [47:0]       last;
		logic [USED_W-1:0] used;
	} rec_t;

endpackage
`default_nettype wire

/* rtl/per_source_flood_guard.sv */
`default_nettype none
// Per-source admission guard: UDP/TCP checks and session up/down against a table of
// RECORDS source records held in one synchronous record memory, with session ids in a
// second memory of RECORDS*SESSIONS_PER_SOURCE words. Records are taken in order and
// never freed, so a fill count tracks the valid ones and no clearing pass runs after
// reset. Each item scans the records in use one per cycle, then, where needed, the
// source's session slots one per cycle, then passes through the update states
// CALC1, CALC2 and DEC (SLOT_RD and SLOT_WR first when a DOWN drops a session);
// DEC waits while the held result stalls; the record memory scan dominates. One item is
// in flight at a time; the next transfer is taken while the previous result waits.
module per_source_flood_guard #(
	parameter int RECORDS = fsg_pkg::RECORDS_DEF,
	parameter int SESSIONS_PER_SOURCE = fsg_pkg::SESSIONS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire fsg_pkg::in_t                in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output fsg_pkg::out_t                    out_data,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fsg_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import fsg_pkg::*;

	localparam int RIDX_W  = $clog2(RECORDS);
	localparam int SADDR_W = $clog2(RECORDS * SESSIONS_PER_SOURCE);

	cfg_t               cfg;
	logic               rec_we, sess_we;
	logic [RIDX_W-1:0]  rec_waddr, rec_raddr;
	rec_t               rec_wdata, rec_rdata;
	logic [SADDR_W-1:0] sess_waddr, sess_raddr;
	logic [31:0]        sess_wdata, sess_rdata;

	fsg_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	fsg_ram #(.WIDTH($bits(rec_t)), .DEPTH(RECORDS)) u_rec_ram (
		.clk, .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(rec_raddr), .rdata(rec_rdata)
	);

	fsg_ram #(.WIDTH(32), .DEPTH(RECORDS * SESSIONS_PER_SOURCE)) u_sess_ram (
		.clk, .we(sess_we), .waddr(sess_waddr), .wdata(sess_wdata),
		.raddr(sess_raddr), .rdata(sess_rdata)
	);

	fsg_engine #(.RECORDS(RECORDS), .SESSIONS_PER_SOURCE(SESSIONS_PER_SOURCE)) u_engine (
		.clk, .arst_n, .cfg,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.rec_we, .rec_waddr, .rec_wdata, .rec_raddr, .rec_rdata,
		.sess_we, .sess_waddr, .sess_wdata, .sess_raddr, .sess_rdata
	);
endmodule
`default_nettype wire

/* rtl/fsg_ram.sv */
`default_nettype none
module fsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/fsg_cfg.sv */
`default_nettype none
module fsg_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fsg_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output fsg_pkg::cfg_t                   cfg
);
	import fsg_pkg::*;

	logic       wr;
	logic [2:0] idx;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.udp_base  <= RST_UDP_BASE;
			cfg_q.udp_extra <= RST_UDP_EXTRA;
			cfg_q.tcp_base  <= RST_TCP_BASE;
			cfg_q.tcp_extra <= RST_TCP_EXTRA;
			cfg_q.ban_base  <= RST_BAN_BASE;
			cfg_q.timeout   <= RST_TIMEOUT;
			cfg_q.trusted   <= RST_TRUSTED;
			cfg_q.max_size  <= RST_MAX_SIZE;
		end else if (wr) begin
			case (idx)
				REG_UDP_BASE:  cfg_q.udp_base  <= pwdata[15:0];
				REG_UDP_EXTRA: cfg_q.udp_extra <= pwdata[15:0];
				REG_TCP_BASE:  cfg_q.tcp_base  <= pwdata[15:0];
				REG_TCP_EXTRA: cfg_q.tcp_extra <= pwdata[15:0];
				REG_BAN_BASE:  cfg_q.ban_base  <= pwdata;
				REG_TIMEOUT:   cfg_q.timeout   <= pwdata;
				REG_TRUSTED:   cfg_q.trusted   <= pwdata;
				REG_MAX_SIZE:  cfg_q.max_size  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_UDP_BASE:  prdata = {16'd0, cfg_q.udp_base};
			REG_UDP_EXTRA: prdata = {16'd0, cfg_q.udp_extra};
			REG_TCP_BASE:  prdata = {16'd0, cfg_q.tcp_base};
			REG_TCP_EXTRA: prdata = {16'd0, cfg_q.tcp_extra};
			REG_BAN_BASE:  prdata = cfg_q.ban_base;
			REG_TIMEOUT:   prdata = cfg_q.timeout;
			REG_TRUSTED:   prdata = cfg_q.trusted;
			REG_MAX_SIZE:  prdata = {16'd0, cfg_q.max_size};
			default:       prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/fsg_engine.sv */
`default_nettype none
module fsg_engine #(
	parameter int RECORDS = fsg_pkg::RECORDS_DEF,
	parameter int SESSIONS_PER_SOURCE = fsg_pkg::SESSIONS_DEF,
	localparam int RIDX_W = $clog2(RECORDS),
	localparam int SADDR_W = $clog2(RECORDS * SESSIONS_PER_SOURCE)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fsg_pkg::cfg_t        cfg,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire fsg_pkg::in_t         in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output fsg_pkg::out_t             out_data,
	output logic                      rec_we,
	output logic [RIDX_W-1:0]         rec_waddr,
	output fsg_pkg::rec_t             rec_wdata,
	output logic [RIDX_W-1:0]         rec_raddr,
	input  wire fsg_pkg::rec_t        rec_rdata,
	output logic                      sess_we,
	output logic [SADDR_W-1:0]        sess_waddr,
	output logic [31:0]               sess_wdata,
	output logic [SADDR_W-1:0]        sess_raddr,
	input  wire logic [31:0]          sess_rdata
);
	import fsg_pkg::*;

	localparam int FILL_W = $clog2(RECORDS + 1);
	localparam int SK_W   = $clog2(SESSIONS_PER_SOURCE + 1);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SCAN    = 8'b0000_0010,
		ST_SESS    = 8'b0000_0100,
		ST_SLOT_RD = 8'b0000_1000,
		ST_SLOT_WR = 8'b0001_0000,
		ST_CALC1   = 8'b0010_0000,
		ST_CALC2   = 8'b0100_0000,
		ST_DEC     = 8'b1000_0000
	} state_t;

	state_t             state_q;
	in_t                item_q;
	logic [FILL_W-1:0]  fill_q, scan_idx_q;
	logic               chk_vld_q, stale_found_q;
	logic [RIDX_W-1:0]  chk_idx_q, stale_idx_q, r_q;
	rec_t               rec_q;
	logic               have_q, found_q, sc_vld_q;
	logic [SK_W-1:0]    sk_q, sc_idx_q, pos_q;
	out_t               out_q;
	logic               out_vld_q;

	logic               win_s1, banned_s1, oversize_s1;
	logic [21:0]        prod_s1;
	logic [36:0]        ban_amt_s1;
	logic [7:0]         viol_new_s1;
	logic [15:0]        cnt_s2;
	logic [22:0]        lim_s2;
	logic [47:0]        exp_s2;

	logic               is_chk, trusted, hit, last_chk, stale, done, need_take, stale_any;
	logic [RIDX_W-1:0]  stale_pick;
	logic               sess_need, sc_hit, sc_done;
	logic [SADDR_W-1:0] sess_base;
	logic               out_free;
	rec_t               fresh, nrec;
	out_t               res;
	logic               rec_mod, sess_add;
	logic [18:0]        five_cnt;
	logic [24:0]        lim5;
	logic               unk_ok, flood;
	logic [2:0]         sh;

	assign is_chk   = (item_q.operation == OP_UDP) || (item_q.operation == OP_TCP);
	assign trusted  = item_q.source_ip == cfg.trusted;
	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign out_free  = !out_vld_q || !out_stall;

	assign rec_raddr = scan_idx_q[RIDX_W-1:0];
	assign hit       = chk_vld_q && (rec_rdata.address == item_q.source_ip);
	assign last_chk  = chk_vld_q && (FILL_W'(chk_idx_q) == fill_q - 1'b1);
	assign stale     = chk_vld_q && !rec_rdata.ban && (rec_rdata.used == '0) &&
		({1'b0, item_q.now_ms} > ({1'b0, rec_rdata.last} + 49'(cfg.timeout)));
	assign done      = (fill_q == '0) || hit || last_chk;
	assign need_take = (is_chk && !trusted) ||
		(item_q.operation == OP_UP && item_q.session_id != 32'd0);
	assign stale_any  = stale_found_q || stale;
	assign stale_pick = stale_found_q ? stale_idx_q : chk_idx_q;
	assign sess_need  = hit && (rec_rdata.used != '0) && (item_q.operation != OP_TCP) &&
		!(item_q.operation == OP_UP && item_q.session_id == 32'd0);

	always_comb begin
		fresh         = '0;
		fresh.address = item_q.source_ip;
	end

	assign sess_base = SADDR_W'(r_q) * SADDR_W'(SESSIONS_PER_SOURCE);
	assign sc_hit    = sc_vld_q && (sess_rdata == item_q.session_id);
	assign sc_done   = sc_hit || (sc_vld_q && (USED_W'(sc_idx_q) == rec_q.used - 1'b1));
	assign sess_raddr = (state_q == ST_SLOT_RD) ?
		sess_base + SADDR_W'(rec_q.used - 1'b1) : sess_base + SADDR_W'(sk_q);

	assign sh = (rec_q.viol >= 8'd5) ? 3'd5 : rec_q.viol[2:0];

	assign five_cnt = {1'b0, cnt_s2, 2'b00} + 19'(cnt_s2);
	assign lim5     = {lim_s2, 2'b00} + 25'(lim_s2);
	assign unk_ok   = (item_q.packet_class == CLS_PING) ? (23'(cnt_s2) > lim_s2) :
		(23'(five_cnt) > lim_s2);
	assign flood    = (item_q.packet_class == CLS_PING) ? (25'(cnt_s2) > lim5) :
		(23'(cnt_s2) > lim_s2);

	always_comb begin
		nrec     = rec_q;
		rec_mod  = 1'b0;
		sess_add = 1'b0;
		res      = '0;
		case (item_q.operation)
			OP_DOWN: begin
				res.allow   = 1'b1;
				res.verdict = V_SESSION;
				if (have_q && found_q) begin
					nrec.used = rec_q.used - 1'b1;
					rec_mod   = 1'b1;
				end
			end
			OP_UP: begin
				if (item_q.session_id == 32'd0) begin
					res.allow   = 1'b1;
					res.verdict = V_SESSION;
				end else if (!have_q) begin
					res.verdict = V_FULL;
				end else begin
					nrec.last = item_q.now_ms;
					rec_mod   = 1'b1;
					if (found_q) begin
						res.allow   = 1'b1;
						res.verdict = V_SESSION;
					end else if (rec_q.used >= USED_W'(SESSIONS_PER_SOURCE)) begin
						res.verdict = V_SET_FULL;
					end else begin
						sess_add    = 1'b1;
						nrec.used   = rec_q.used + 1'b1;
						res.allow   = 1'b1;
						res.verdict = V_SESSION;
					end
				end
			end
			default: begin
				if (trusted) begin
					res.allow   = 1'b1;
					res.verdict = V_TRUSTED;
				end else if (!have_q) begin
					res.verdict = V_FULL;
				end else begin
					nrec.last = item_q.now_ms;
					rec_mod   = 1'b1;
					if (banned_s1) begin
						res.verdict = V_BANNED;
					end else begin
						nrec.ban = 1'b0;
						if (item_q.operation == OP_TCP) begin
							if (win_s1) begin
								nrec.tcp_ws = item_q.now_ms;
							end
							nrec.tcp_cnt = cnt_s2;
							if (23'(cnt_s2) > lim_s2) begin
								res.verdict    = V_FLOOD;
								res.ban_issued = 1'b1;
							end else begin
								res.allow   = 1'b1;
								res.verdict = V_OK;
							end
						end else if (oversize_s1) begin
							res.verdict    = V_OVERSIZE;
							res.ban_issued = 1'b1;
						end else begin
							if (win_s1) begin
								nrec.udp_ws = item_q.now_ms;
							end
							nrec.udp_cnt = cnt_s2;
							if (!(item_q.session_id != 32'd0 && found_q) &&
								item_q.packet_class != CLS_REG &&
								rec_q.used != '0 && unk_ok) begin
								res.verdict = V_UNKNOWN;
							end else if (flood) begin
								res.verdict    = V_FLOOD;
								res.ban_issued = 1'b1;
							end else begin
								res.allow   = 1'b1;
								res.verdict = V_OK;
							end
						end
						if (res.ban_issued) begin
							nrec.ban    = 1'b1;
							nrec.viol   = viol_new_s1;
							nrec.expiry = exp_s2;
						end
					end
				end
			end
		endcase
		res.live_sessions   = have_q ? nrec.used[3:0] : 4'd0;
		res.violation_total = have_q ? nrec.viol : 8'd0;
	end

	assign rec_we     = (state_q == ST_DEC) && out_free && rec_mod;
	assign rec_waddr  = r_q;
	assign rec_wdata  = nrec;
	assign sess_we    = (state_q == ST_SLOT_WR) ||
		((state_q == ST_DEC) && out_free && sess_add);
	assign sess_waddr = (state_q == ST_SLOT_WR) ? sess_base + SADDR_W'(pos_q) :
		sess_base + SADDR_W'(rec_q.used);
	assign sess_wdata = (state_q == ST_SLOT_WR) ? sess_rdata : item_q.session_id;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == ST_SCAN) begin
			if (done) begin
				if (hit) begin
					rec_q <= rec_rdata;
					r_q   <= chk_idx_q;
				end else if (need_take && fill_q < FILL_W'(RECORDS)) begin
					rec_q <= fresh;
					r_q   <= fill_q[RIDX_W-1:0];
				end else if (need_take && stale_any) begin
					rec_q <= fresh;
					r_q   <= stale_pick;
				end else begin
					rec_q <= '0;
				end
			end else if (stale && !stale_found_q) begin
				stale_idx_q <= chk_idx_q;
			end
			chk_idx_q <= scan_idx_q[RIDX_W-1:0];
		end
		if (state_q == ST_SESS) begin
			sc_idx_q <= sk_q;
			if (sc_done) begin
				pos_q <= sc_idx_q;
			end
		end
		if (state_q == ST_CALC1) begin
			if (item_q.operation == OP_TCP) begin
				win_s1  <= {1'b0, item_q.now_ms} > ({1'b0, rec_q.tcp_ws} + 49'(TCP_WINDOW_MS));
				prod_s1 <= 22'(rec_q.used) * 22'(cfg.tcp_extra);
			end else begin
				win_s1  <= {1'b0, item_q.now_ms} > ({1'b0, rec_q.udp_ws} + 49'(UDP_WINDOW_MS));
				prod_s1 <= 22'(rec_q.used) * 22'(cfg.udp_extra);
			end
			banned_s1   <= rec_q.ban && (item_q.now_ms < rec_q.expiry);
			oversize_s1 <= item_q.datagram_size > cfg.max_size;
			ban_amt_s1  <= 37'(cfg.ban_base) << sh;
			viol_new_s1 <= (rec_q.viol == 8'hFF) ? 8'hFF : rec_q.viol + 1'b1;
		end
		if (state_q == ST_CALC2) begin
			if (win_s1) begin
				cnt_s2 <= 16'd1;
			end else if (item_q.operation == OP_TCP) begin
				cnt_s2 <= (rec_q.tcp_cnt == 16'hFFFF) ? 16'hFFFF : rec_q.tcp_cnt + 1'b1;
			end else begin
				cnt_s2 <= (rec_q.udp_cnt == 16'hFFFF) ? 16'hFFFF : rec_q.udp_cnt + 1'b1;
			end
			lim_s2 <= ((item_q.operation == OP_TCP) ? 23'(cfg.tcp_base) : 23'(cfg.udp_base)) +
				23'(prod_s1);
			exp_s2 <= (({1'b0, item_q.now_ms} + 49'(ban_amt_s1)) > 49'({48{1'b1}})) ?
				{48{1'b1}} : 48'({1'b0, item_q.now_ms} + 49'(ban_amt_s1));
		end
		if (state_q == ST_DEC && out_free) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fill_q        <= '0;
			scan_idx_q    <= '0;
			chk_vld_q     <= 1'b0;
			stale_found_q <= 1'b0;
			have_q        <= 1'b0;
			found_q       <= 1'b0;
			sk_q          <= '0;
			sc_vld_q      <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (state_q == ST_DEC && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						scan_idx_q    <= '0;
						chk_vld_q     <= 1'b0;
						stale_found_q <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q < fill_q) begin
						chk_vld_q  <= 1'b1;
						scan_idx_q <= scan_idx_q + 1'b1;
					end else begin
						chk_vld_q <= 1'b0;
					end
					if (stale) begin
						stale_found_q <= 1'b1;
					end
					if (done) begin
						found_q  <= 1'b0;
						sk_q     <= '0;
						sc_vld_q <= 1'b0;
						if (hit) begin
							have_q <= 1'b1;
						end else if (need_take && fill_q < FILL_W'(RECORDS)) begin
							have_q <= 1'b1;
							fill_q <= fill_q + 1'b1;
						end else begin
							have_q <= need_take && stale_any;
						end
						state_q <= sess_need ? ST_SESS : ST_CALC1;
					end
				end
				ST_SESS: begin
					if (USED_W'(sk_q) < rec_q.used) begin
						sc_vld_q <= 1'b1;
						sk_q     <= sk_q + 1'b1;
					end else begin
						sc_vld_q <= 1'b0;
					end
					if (sc_done) begin
						found_q <= sc_hit;
						state_q <= (sc_hit && item_q.operation == OP_DOWN) ?
							ST_SLOT_RD : ST_CALC1;
					end
				end
				ST_SLOT_RD: state_q <= ST_SLOT_WR;
				ST_SLOT_WR: state_q <= ST_CALC1;
				ST_CALC1:   state_q <= ST_CALC2;
				ST_CALC2:   state_q <= ST_DEC;
				ST_DEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RECORDS))
		else $error("record fill count beyond table size");

	a_rec_write_known: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> (FILL_W'(r_q) < fill_q))
		else $error("record write outside the records in use");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> (rec_wdata.used <= USED_W'(SESSIONS_PER_SOURCE)))
		else $error("session count beyond set size");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC && out_free) |=> (out_vld_q && state_q == ST_IDLE))
		else $error("decision did not load the result register");

endmodule
`default_nettype wire
